@@ sv/char_lcd_shadow_refresh_top_assert.svh @@
// assertion macros for the shadow screen refresher
// used by char_lcd_shadow_refresh_top; expects clk and rst_n in scope
`ifndef CHAR_LCD_SHADOW_REFRESH_TOP_ASSERT_SVH
`define CHAR_LCD_SHADOW_REFRESH_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define CLSR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("shadow refresh check failed (same cycle)");
`define CLSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("shadow refresh check failed (next cycle)");
`else
`define CLSR_ASSERT_SAME(lbl, ante, cons)
`define CLSR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/clsr_pkg.sv @@
// shared types, constants and helpers for the shadow screen refresher
// no dependencies
`default_nettype none

package clsr_pkg;

  localparam int ROWS_DEF    = 4;
  localparam int COLUMNS_DEF = 20;
  localparam int ROW_W       = 2;
  localparam int COL_W       = 5;
  localparam int IDX_W       = 7;
  localparam int SPT_W       = 7;
  localparam int QDEPTH      = 2;

  localparam logic [SPT_W-1:0] SPT_RESET = 7'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [7:0] BASE_ROW0 = 8'h80;
  localparam logic [7:0] BASE_ROW1 = 8'hC0;
  localparam logic [7:0] BASE_ROW2 = 8'h94;
  localparam logic [7:0] BASE_ROW3 = 8'hD4;

  typedef struct packed {
    logic       op;
    logic [2:0] row;
    logic [4:0] column;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    logic             is_tick;
    logic [IDX_W-1:0] idx;
    logic [7:0]       char_code;
  } q_item_t;

  typedef struct packed {
    logic busy;
    logic emitting;
  } back_status_t;

  // ddram address of column 0 of a row
  function automatic logic [7:0] row_base(input logic [ROW_W-1:0] r);
    logic [7:0] b;
    unique case (r)
      2'd0:    b = BASE_ROW0;
      2'd1:    b = BASE_ROW1;
      2'd2:    b = BASE_ROW2;
      default: b = BASE_ROW3;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ sv/char_lcd_shadow_refresh_top.sv @@
// Shadow screen refresher for a character display of ROWS x COLUMNS cells. A write
// item stores a character in a cell and marks it dirty; writes outside the screen are
// dropped. A tick item scans up to scan_per_tick cells from a rotating position and
// sends at most one byte: a set-DDRAM-address command when the cursor is not on the
// first dirty cell, otherwise the character. Items are queued (two entries) and carried
// out one at a time by the scan sequencer. A write is carried out as it leaves the
// queue. A tick first loads its scan count, then examines the cells in turn; sending a
// character passes through an emit state (its read from the cell store is registered)
// and a scan that finds no dirty cell ends when its count runs out. A new result waits
// while the previous one is still stalled at the output. The dirty marks are cleared
// by reset; no clearing pass is needed. scan_per_tick resets to two.
// depends on clsr_pkg, clsr_front, clsr_back and char_lcd_shadow_refresh_top_assert.svh
`default_nettype none

`include "char_lcd_shadow_refresh_top_assert.svh"

module char_lcd_shadow_refresh_top #(
  parameter int ROWS    = clsr_pkg::ROWS_DEF,
  parameter int COLUMNS = clsr_pkg::COLUMNS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [clsr_pkg::SPT_W-1:0] cfg_wdata,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire clsr_pkg::in_item_t         in_item,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      clsr_pkg::out_item_t        out_item
);

  logic                   q_valid;
  clsr_pkg::q_item_t      q_item;
  logic                   q_pop;
  clsr_pkg::back_status_t status;

  // accept and classify
  clsr_front #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // execute and deliver
  clsr_back #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .status    (status)
  );

  // checks
  `CLSR_ASSERT_SAME(a_pop_needs_entry, q_pop, q_valid)
  `CLSR_ASSERT_SAME(a_new_result_from_scan, $rose(out_valid), $past(status.busy))
  `CLSR_ASSERT_NEXT(a_write_gives_no_result, in_valid && !in_stall && (in_item.op == clsr_pkg::OP_WRITE) && !q_valid && !status.busy && !out_valid, !out_valid)
  `CLSR_ASSERT_NEXT(a_emit_sends_data, status.emitting && (!out_valid || !out_stall), out_valid && out_item.is_data)

endmodule

`default_nettype wire

@@ sv/clsr_front.sv @@
// front end: accepts items, drops out-of-range writes, queues commands
// depends on clsr_pkg
`default_nettype none

module clsr_front #(
  parameter int ROWS    = clsr_pkg::ROWS_DEF,
  parameter int COLUMNS = clsr_pkg::COLUMNS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_stall,
  input  wire clsr_pkg::in_item_t in_item,
  output      logic               q_valid,
  output      clsr_pkg::q_item_t  q_item,
  input  wire logic               q_pop
);

  localparam int PTR_W = $clog2(clsr_pkg::QDEPTH);
  localparam int CNT_W = $clog2(clsr_pkg::QDEPTH + 1);

  clsr_pkg::q_item_t q_mem_r [clsr_pkg::QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  logic              accept;
  logic              in_range;
  logic              push;
  logic              pop;
  clsr_pkg::q_item_t cls_item;

  // classify the incoming item
  always_comb begin
    in_range = ({1'b0, in_item.row} < 4'(ROWS)) && ({1'b0, in_item.column} < 6'(COLUMNS));
    cls_item.is_tick   = (in_item.op == clsr_pkg::OP_TICK);
    cls_item.idx       = clsr_pkg::IDX_W'(int'(in_item.row) * COLUMNS + int'(in_item.column));
    cls_item.char_code = in_item.char_code;
  end

  assign in_stall = (count_r == CNT_W'(clsr_pkg::QDEPTH));
  assign accept   = in_valid && !in_stall;
  assign push     = accept && (cls_item.is_tick || in_range);
  assign pop      = q_pop && (count_r != '0);

  assign q_valid = (count_r != '0);
  assign q_item  = q_mem_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push ? PTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop ? PTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cls_item;
    end
  end

endmodule

`default_nettype wire

@@ sv/clsr_back.sv @@
// back end: cell store, dirty marks, scan sequencer and output register
// depends on clsr_pkg
`default_nettype none

module clsr_back #(
  parameter int ROWS    = clsr_pkg::ROWS_DEF,
  parameter int COLUMNS = clsr_pkg::COLUMNS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [clsr_pkg::SPT_W-1:0]   cfg_wdata,
  input  wire logic                         q_valid,
  input  wire clsr_pkg::q_item_t            q_item,
  output      logic                         q_pop,
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      clsr_pkg::out_item_t          out_item,
  output      clsr_pkg::back_status_t       status
);

  localparam int CELLS = ROWS * COLUMNS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]                 state_r, state_nxt;
  logic [clsr_pkg::SPT_W-1:0] spt_r;
  logic [clsr_pkg::SPT_W-1:0] cnt_r, cnt_nxt;
  logic [clsr_pkg::ROW_W-1:0] scan_row_r, scan_row_nxt;
  logic [clsr_pkg::COL_W-1:0] scan_col_r, scan_col_nxt;
  logic [clsr_pkg::IDX_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [clsr_pkg::ROW_W-1:0] prev_row_r, prev_row_nxt;
  logic [clsr_pkg::COL_W-1:0] prev_col_r, prev_col_nxt;
  logic                       prev_valid_r, prev_valid_nxt;
  logic [CELLS-1:0]           dirty_r, dirty_nxt;
  logic                       out_valid_r, out_valid_nxt;
  clsr_pkg::out_item_t        out_item_r, out_item_nxt;

  logic [7:0]                 cell_mem [CELLS];
  logic [7:0]                 rd_data_r;
  logic                       mem_we;

  logic                       can_load;
  logic                       cursor_miss;
  logic [clsr_pkg::ROW_W-1:0] adv_row;
  logic [clsr_pkg::COL_W-1:0] adv_col;
  logic [clsr_pkg::IDX_W-1:0] adv_idx;

  assign can_load    = !out_valid_r || !out_stall;
  assign cursor_miss = !prev_valid_r || (prev_row_r != scan_row_r) || (prev_col_r != scan_col_r);

  // next scan position, wrapping by column then row
  always_comb begin
    if (scan_col_r == clsr_pkg::COL_W'(COLUMNS - 1)) begin
      adv_col = '0;
      adv_row = (scan_row_r == clsr_pkg::ROW_W'(ROWS - 1)) ? '0
                : clsr_pkg::ROW_W'(scan_row_r + 1'b1);
    end else begin
      adv_col = clsr_pkg::COL_W'(scan_col_r + 1'b1);
      adv_row = scan_row_r;
    end
    adv_idx = (scan_idx_r == clsr_pkg::IDX_W'(CELLS - 1)) ? '0
              : clsr_pkg::IDX_W'(scan_idx_r + 1'b1);
  end

  // scan sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    scan_row_nxt   = scan_row_r;
    scan_col_nxt   = scan_col_r;
    scan_idx_nxt   = scan_idx_r;
    prev_row_nxt   = prev_row_r;
    prev_col_nxt   = prev_col_r;
    prev_valid_nxt = prev_valid_r;
    dirty_nxt      = dirty_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_item_nxt   = out_item_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.is_tick) begin
            cnt_nxt   = spt_r;
            state_nxt = ST_SCAN;
          end else begin
            mem_we                 = 1'b1;
            dirty_nxt[q_item.idx]  = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (cnt_r == '0) begin
          state_nxt = ST_IDLE;
        end else if (dirty_r[scan_idx_r]) begin
          if (!cursor_miss) begin
            // cell data is read into a register here and sent from the emit state
            state_nxt = ST_EMIT;
          end else if (can_load) begin
            out_valid_nxt         = 1'b1;
            out_item_nxt.lcd_byte = 8'(clsr_pkg::row_base(scan_row_r) + {3'b000, scan_col_r});
            out_item_nxt.is_data  = 1'b0;
            prev_row_nxt          = scan_row_r;
            prev_col_nxt          = scan_col_r;
            prev_valid_nxt        = 1'b1;
            state_nxt             = ST_IDLE;
          end
        end else begin
          scan_row_nxt = adv_row;
          scan_col_nxt = adv_col;
          scan_idx_nxt = adv_idx;
          cnt_nxt      = clsr_pkg::SPT_W'(cnt_r - 1'b1);
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.lcd_byte  = rd_data_r;
          out_item_nxt.is_data   = 1'b1;
          dirty_nxt[scan_idx_r]  = 1'b0;
          prev_row_nxt           = scan_row_r;
          prev_col_nxt           = clsr_pkg::COL_W'(scan_col_r + 1'b1);
          prev_valid_nxt         = 1'b1;
          scan_row_nxt           = adv_row;
          scan_col_nxt           = adv_col;
          scan_idx_nxt           = adv_idx;
          state_nxt              = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      spt_r        <= clsr_pkg::SPT_RESET;
      cnt_r        <= '0;
      scan_row_r   <= '0;
      scan_col_r   <= '0;
      scan_idx_r   <= '0;
      prev_row_r   <= '0;
      prev_col_r   <= '0;
      prev_valid_r <= 1'b0;
      dirty_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      if (cfg_we) begin
        spt_r <= cfg_wdata;
      end
      cnt_r        <= cnt_nxt;
      scan_row_r   <= scan_row_nxt;
      scan_col_r   <= scan_col_nxt;
      scan_idx_r   <= scan_idx_nxt;
      prev_row_r   <= prev_row_nxt;
      prev_col_r   <= prev_col_nxt;
      prev_valid_r <= prev_valid_nxt;
      dirty_r      <= dirty_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  // character store: one write port, one registered read at the scan position
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[q_item.idx] <= q_item.char_code;
    end
    rd_data_r <= cell_mem[scan_idx_r];
  end

  assign out_valid       = out_valid_r;
  assign out_item        = out_item_r;
  assign status.busy     = (state_r != ST_IDLE);
  assign status.emitting = (state_r == ST_EMIT);

endmodule

`default_nettype wire

@@ tb/char_lcd_shadow_refresh_top_tb.sv @@
// testbench for char_lcd_shadow_refresh_top: a directed script, then random phases at several
// scan limits, checked against the script's typed-in bytes or a bench shadow screen predictor
// depends on clsr_pkg and char_lcd_shadow_refresh_top
`timescale 1ns / 1ps

module char_lcd_shadow_refresh_top_tb;

  localparam int ROWS          = clsr_pkg::ROWS_DEF;
  localparam int COLUMNS       = clsr_pkg::COLUMNS_DEF;
  localparam int CELLS         = ROWS * COLUMNS;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 200;
  localparam int HOLD_AFTER    = 40;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SCRIPT_LEN    = 24;
  localparam int PHASES        = 7;

  localparam logic [7:0] ROW_ADDR [4] = '{clsr_pkg::BASE_ROW0, clsr_pkg::BASE_ROW1,
                                          clsr_pkg::BASE_ROW2, clsr_pkg::BASE_ROW3};

  // one scripted transfer: the item, and a typed-in byte where it is obvious
  typedef struct packed {
    clsr_pkg::in_item_t  item;
    logic                typed;
    clsr_pkg::out_item_t want;
  } script_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [clsr_pkg::SPT_W-1:0] cfg_wdata;
  logic                       in_valid;
  logic                       in_stall;
  clsr_pkg::in_item_t         in_item;
  logic                       out_valid;
  logic                       out_stall;
  clsr_pkg::out_item_t        out_item;

  // shadow of the block's screen and scan state
  logic [7:0]           shadow_char [CELLS];
  bit                   shadow_dirty [CELLS];
  logic [1:0]           scan_r;
  logic [4:0]           scan_c;
  logic [1:0]           cursor_r;
  logic [4:0]           cursor_c;
  bit                   cursor_known;
  int                   scan_limit;

  clsr_pkg::out_item_t  lcd_bytes_due [$];
  int                   mismatches;
  int                   bytes_seen;
  bit                   idle_off;

  // directed script, run at the reset scan limit of two
  script_row_t script [SCRIPT_LEN] = '{
    {clsr_pkg::OP_TICK,  3'd7, 5'd31, 8'hFF, 1'b0, 8'h00, 1'b0},  // empty screen, scan moves on
    {clsr_pkg::OP_WRITE, 3'd0, 5'd2,  8'h41, 1'b0, 8'h00, 1'b0},
    {clsr_pkg::OP_TICK,  3'd0, 5'd0,  8'h00, 1'b1, 8'h82, 1'b0},  // cursor unknown: address
    {clsr_pkg::OP_TICK,  3'd5, 5'd17, 8'h3C, 1'b1, 8'h41, 1'b1},
    {clsr_pkg::OP_WRITE, 3'd0, 5'd3,  8'hFF, 1'b0, 8'h00, 1'b0},
    {clsr_pkg::OP_TICK,  3'd2, 5'd10, 8'h80, 1'b1, 8'hFF, 1'b1},  // cursor follows on
    {clsr_pkg::OP_WRITE, 3'd0, 5'd5,  8'h00, 1'b0, 8'h00, 1'b0},
    {clsr_pkg::OP_TICK,  3'd0, 5'd0,  8'h00, 1'b1, 8'h85, 1'b0},  // skips a clean cell
    {clsr_pkg::OP_TICK,  3'd0, 5'd0,  8'h00, 1'b1, 8'h00, 1'b1},
    {clsr_pkg::OP_WRITE, 3'd0, 5'd19, 8'h7E, 1'b0, 8'h00, 1'b0},
    {clsr_pkg::OP_WRITE, 3'd1, 5'd0,  8'h31, 1'b0, 8'h00, 1'b0},
    {clsr_pkg::OP_WRITE, 3'd4, 5'd6,  8'h55, 1'b0, 8'h00, 1'b0},  // row off screen, dropped
    {clsr_pkg::OP_WRITE, 3'd0, 5'd20, 8'h66, 1'b0, 8'h00, 1'b0},  // past last column, dropped
    {clsr_pkg::OP_WRITE, 3'd7, 5'd31, 8'hAA, 1'b0, 8'h00, 1'b0},
    {clsr_pkg::OP_TICK,  3'd0, 5'd0,  8'h00, 1'b0, 8'h00, 1'b0},
    {clsr_pkg::OP_TICK,  3'd1, 5'd1,  8'h01, 1'b0, 8'h00, 1'b0},
    {clsr_pkg::OP_TICK,  3'd2, 5'd2,  8'h02, 1'b0, 8'h00, 1'b0},
    {clsr_pkg::OP_TICK,  3'd4, 5'd4,  8'h04, 1'b0, 8'h00, 1'b0},
    {clsr_pkg::OP_TICK,  3'd0, 5'd8,  8'h08, 1'b0, 8'h00, 1'b0},
    {clsr_pkg::OP_TICK,  3'd0, 5'd16, 8'h10, 1'b0, 8'h00, 1'b0},
    {clsr_pkg::OP_TICK,  3'd0, 5'd0,  8'h00, 1'b1, 8'h93, 1'b0},
    {clsr_pkg::OP_TICK,  3'd0, 5'd0,  8'h00, 1'b1, 8'h7E, 1'b1},
    {clsr_pkg::OP_TICK,  3'd0, 5'd0,  8'h00, 1'b1, 8'hC0, 1'b0},  // cursor past last column
    {clsr_pkg::OP_TICK,  3'd0, 5'd0,  8'h00, 1'b1, 8'h31, 1'b1}
  };

  // random phases: scan limit (-1 draws one), item count, no-idle flag
  int phase_limit [PHASES] = '{2, 1, 80, 0, 127, -1, 5};
  int phase_items [PHASES] = '{200, 120, 180, 30, 60, 150, 80};
  bit phase_calm  [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1};

  char_lcd_shadow_refresh_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  // 4 ns clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void step_scan_pos();
    if (scan_c == 5'(COLUMNS - 1)) begin
      scan_c = '0;
      scan_r = (scan_r == 2'(ROWS - 1)) ? 2'd0 : scan_r + 2'd1;
    end else begin
      scan_c = scan_c + 5'd1;
    end
  endfunction

  // next byte the display gets for one item; returns 0 when nothing is sent
  function automatic bit predict_display_byte(input clsr_pkg::in_item_t it,
                                              output clsr_pkg::out_item_t res);
    int idx;
    int n;
    bit sent;
    sent = 1'b0;
    res = '0;
    if (it.op == clsr_pkg::OP_WRITE) begin
      if (it.row < ROWS && it.column < COLUMNS) begin
        idx = it.row * COLUMNS + it.column;
        shadow_char[idx] = it.char_code;
        shadow_dirty[idx] = 1'b1;
      end
    end else begin
      for (n = 0; n < scan_limit && !sent; n++) begin
        idx = scan_r * COLUMNS + scan_c;
        if (shadow_dirty[idx]) begin
          sent = 1'b1;
          if (!cursor_known || cursor_r != scan_r || cursor_c != scan_c) begin
            // cursor elsewhere: address the cell, scan stays on it
            res.lcd_byte = ROW_ADDR[scan_r] + 8'(scan_c);
            res.is_data = 1'b0;
            cursor_r = scan_r;
            cursor_c = scan_c;
          end else begin
            res.lcd_byte = shadow_char[idx];
            res.is_data = 1'b1;
            shadow_dirty[idx] = 1'b0;
            cursor_r = scan_r;
            cursor_c = scan_c + 5'd1;
            step_scan_pos();
          end
          cursor_known = 1'b1;
        end else begin
          step_scan_pos();
        end
      end
    end
    return sent;
  endfunction

  // offer one item after a random gap, then log what it should produce
  task automatic send_item(input clsr_pkg::in_item_t it, input logic typed,
                           input clsr_pkg::out_item_t want);
    int gap;
    clsr_pkg::out_item_t res;
    gap = idle_off ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_item <= clsr_pkg::in_item_t'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_display_byte(it, res)) begin
      lcd_bytes_due.push_back(typed ? want : res);
    end else if (typed) begin
      lcd_bytes_due.push_back(want);
    end
  endtask

  task automatic send_random(input clsr_pkg::in_item_t it);
    send_item(it, 1'b0, '0);
  endtask

  function automatic clsr_pkg::in_item_t random_item();
    clsr_pkg::in_item_t it;
    int pick;
    pick = $urandom_range(0, 99);
    it.op = clsr_pkg::OP_WRITE;
    it.row = 3'($urandom_range(0, ROWS - 1));
    it.column = 5'($urandom_range(0, COLUMNS - 1));
    it.char_code = 8'($urandom_range(0, 255));
    if (pick < 45) begin
      it.op = clsr_pkg::OP_TICK;
      it.row = 3'($urandom_range(0, 7));
      it.column = 5'($urandom_range(0, 31));
    end else if (pick < 50) begin
      it.row = 3'($urandom_range(ROWS, 7));
    end else if (pick < 55) begin
      it.column = 5'($urandom_range(COLUMNS, 31));
    end
    return it;
  endfunction

  // drop valid, wait for every byte due, then let a slow empty tick finish
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (lcd_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_scan_limit(input int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= clsr_pkg::SPT_W'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    scan_limit = value;
  endtask

  // stimulus
  initial begin
    int p;
    int k;
    int sent;
    int run_len;
    int limit;
    clsr_pkg::in_item_t it;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_item = '0;
    idle_off = 1'b0;
    mismatches = 0;
    scan_limit = clsr_pkg::SPT_RESET;
    scan_r = '0;
    scan_c = '0;
    cursor_r = '0;
    cursor_c = '0;
    cursor_known = 1'b0;
    for (k = 0; k < CELLS; k++) begin
      shadow_char[k] = '0;
      shadow_dirty[k] = 1'b0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed script
    for (k = 0; k < SCRIPT_LEN; k++) begin
      send_item(script[k].item, script[k].typed, script[k].want);
    end

    // random phases, scan limit changed only while idle
    for (p = 0; p < PHASES; p++) begin
      settle();
      limit = (phase_limit[p] < 0) ? $urandom_range(3, 40) : phase_limit[p];
      write_scan_limit(limit);
      idle_off = phase_calm[p];
      sent = 0;
      while (sent < phase_items[p]) begin
        if ($urandom_range(0, 9) == 0) begin
          // a short string written into consecutive cells of one row
          it.op = clsr_pkg::OP_WRITE;
          it.row = 3'($urandom_range(0, ROWS - 1));
          it.column = 5'($urandom_range(0, COLUMNS - 1));
          run_len = $urandom_range(2, 6);
          for (k = 0; k < run_len && it.column < COLUMNS; k++) begin
            it.char_code = 8'($urandom_range(0, 255));
            send_random(it);
            it.column = it.column + 5'd1;
            sent++;
          end
        end else begin
          send_random(random_item());
          sent++;
        end
      end
    end
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // result side stall pattern, with one long hold so the input side backs up
  initial begin
    int gap;
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      gap = idle_off ? 0 : $urandom_range(0, 17);
      if (!hold_done && bytes_seen >= HOLD_AFTER) begin
        gap = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (gap != 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // check each result transfer against the oldest byte due
  initial bytes_seen = 0;
  always @(posedge clk) begin
    clsr_pkg::out_item_t due;
    if (rst_n && out_valid && !out_stall) begin
      bytes_seen++;
      if (lcd_bytes_due.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h is_data %0b",
                                  out_item.lcd_byte, out_item.is_data));
      end else begin
        due = lcd_bytes_due.pop_front();
        if (out_item.lcd_byte !== due.lcd_byte)
          report_mismatch($sformatf("lcd_byte %02h, want %02h",
                                    out_item.lcd_byte, due.lcd_byte));
        if (out_item.is_data !== due.is_data)
          report_mismatch($sformatf("is_data %0b, want %0b",
                                    out_item.is_data, due.is_data));
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb: failure");
    $finish;
  end

endmodule

@@ char_lcd_shadow_refresh_top.f @@
+incdir+sv
sv/clsr_pkg.sv
sv/clsr_front.sv
sv/clsr_back.sv
sv/char_lcd_shadow_refresh_top.sv
tb/char_lcd_shadow_refresh_top_tb.sv
